[rtl/core/gses_pkg.sv]
// Package for the greedy spaced edit selector.
// Item types, store entry types, sizes and constants; no dependencies.
package gses_pkg;

    localparam int MAX_EDITS = 64;
    localparam int IDX_W = $clog2(MAX_EDITS);
    localparam int CNT_W = $clog2(MAX_EDITS + 1);

    localparam logic [23:0] POS_MAX = 24'hFFFFFF;
    localparam logic [13:0] BASES_MAX = 14'h3FFF;
    localparam logic [7:0] GUARD_RESET = 8'd10;

    // one loaded edit
    typedef struct packed {
        logic [23:0]        edit_start;
        logic [7:0]         original_length;
        logic [7:0]         replacement_length;
        logic signed [31:0] edit_score;
        logic               final_edit;
    } edit_item_t;

    // one result
    typedef struct packed {
        logic               entry_valid;
        logic               was_kept;
        logic [23:0]        adjusted_start;
        logic [7:0]         out_original_length;
        logic [7:0]         out_replacement_length;
        logic signed [31:0] out_score;
        logic [13:0]        bases_changed;
        logic               final_result;
    } result_item_t;

    // store entry, load order
    typedef struct packed {
        logic [23:0]        start;
        logic [7:0]         olen;
        logic [7:0]         rlen;
        logic signed [31:0] score;
    } edit_entry_t;

    // work entry, sorted order
    typedef struct packed {
        edit_entry_t edit;
        logic        deferred;
    } work_entry_t;

endpackage

[rtl/core/gses_load_mem.sv]
// Load-order edit store: one write port, one registered read port.
// Depends on gses_pkg.
module gses_load_mem
    import gses_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  edit_entry_t       wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output edit_entry_t       rd_data
);

    edit_entry_t mem [MAX_EDITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/gses_work_mem.sv]
// Sorted work store: start, lengths, score and deferred mark per rank.
// Depends on gses_pkg.
module gses_work_mem
    import gses_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  work_entry_t       wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output work_entry_t       rd_data
);

    work_entry_t mem [MAX_EDITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/greedy_spaced_edit_selector_top.sv]
// Greedy spaced edit selector, top level: sequencer around two stores.
// Depends on gses_pkg, gses_load_mem, gses_work_mem.
//
//  Channel   Signals                          Dir  Moves
//  config    cfg_wr_en, cfg_wr_data           in   guard_spacing write
//  edit      edit_valid, edit_stall, edit     in   one candidate edit item
//  result    result_valid, result_stall, res  out  one result item
//
// Loading takes one edit per cycle into the load store.
// Ranking then compares each surviving edit with every loaded one, one compare per cycle
// through the load store read port; dropped edits skip the compare. The walk scans the
// later entries for each kept edit through the work store port and emits one result per entry.
// Reset clears control state and sets guard_spacing to 10; stores need no clear.
// A stalled result holds in the output register; the next batch may load meanwhile.
module greedy_spaced_edit_selector_top
    import gses_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  logic          edit_valid,
    output logic          edit_stall,
    input  edit_item_t    edit,
    output logic          result_valid,
    input  logic          result_stall,
    output result_item_t  result
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_R_RDI  = 4'd1;
    localparam logic [3:0] S_R_GETI = 4'd2;
    localparam logic [3:0] S_R_CNT  = 4'd3;
    localparam logic [3:0] S_R_WR   = 4'd4;
    localparam logic [3:0] S_W_RDI  = 4'd5;
    localparam logic [3:0] S_W_GETI = 4'd6;
    localparam logic [3:0] S_W_J    = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [13:0]      base_reg, base_next;
    logic [7:0]       guard_reg;
    logic             kept_reg, kept_next;
    edit_entry_t      cur_reg, cur_next;
    logic             res_valid_reg, res_valid_next;
    result_item_t     res_reg, res_next;

    logic             edit_take;
    logic             slot_free;
    logic             load_wr;
    edit_entry_t      load_wdata, load_rd;
    logic [IDX_W-1:0] load_raddr;
    logic             work_wr;
    logic [IDX_W-1:0] work_waddr, work_raddr;
    work_entry_t      work_wdata, work_rd;

    // ranking compare
    logic             better;
    // walk arithmetic
    logic [24:0]      end_i, end_j, lo, hi, kept_end;
    logic [25:0]      hi_pad;
    logic             near;
    logic signed [25:0] shifted;
    logic [23:0]      shifted_sat;
    logic [14:0]      base_sum;

    assign edit_stall   = (state_reg != S_LOAD);
    assign edit_take    = edit_valid && !edit_stall;
    assign slot_free    = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // stores
    gses_load_mem u_load_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (load_wdata),
        .rd_addr (load_raddr),
        .rd_data (load_rd)
    );

    gses_work_mem u_work_mem (
        .clk     (clk),
        .wr_en   (work_wr),
        .wr_addr (work_waddr),
        .wr_data (work_wdata),
        .rd_addr (work_raddr),
        .rd_data (work_rd)
    );

    assign load_wr    = edit_take && (cnt_reg < CNT_W'(MAX_EDITS));
    assign load_wdata = '{start: edit.edit_start, olen: edit.original_length,
                          rlen: edit.replacement_length, score: edit.edit_score};

    // guard spacing register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg <= GUARD_RESET;
        end
        else if (cfg_wr_en)
        begin
            guard_reg <= cfg_wr_data;
        end
    end

    // ranking: a non-negative j ranks ahead of i on higher score, or equal score and earlier load
    assign better = (load_rd.score >= 0) &&
                    ((load_rd.score > cur_reg.score) ||
                     ((load_rd.score == cur_reg.score) && (j_reg < i_reg)));

    // overlap and shift of entry j against kept entry i
    assign end_i    = {1'b0, cur_reg.start} + 25'(cur_reg.rlen);
    assign end_j    = {1'b0, work_rd.edit.start} + 25'(work_rd.edit.rlen);
    assign lo       = (cur_reg.start > work_rd.edit.start) ? {1'b0, cur_reg.start}
                                                           : {1'b0, work_rd.edit.start};
    assign hi       = (end_i < end_j) ? end_i : end_j;
    assign hi_pad   = {1'b0, hi} + 26'(guard_reg);
    assign near     = {1'b0, lo} < hi_pad;
    assign kept_end = {1'b0, cur_reg.start} + 25'(cur_reg.olen);
    assign shifted  = $signed({2'b00, work_rd.edit.start}) + $signed(26'(cur_reg.rlen))
                      - $signed(26'(cur_reg.olen));
    assign shifted_sat = (shifted < 0) ? 24'd0 :
                         (shifted > $signed({2'b00, POS_MAX})) ? POS_MAX : shifted[23:0];
    assign base_sum = {1'b0, base_reg} +
                      15'((work_rd.edit.olen > work_rd.edit.rlen) ? work_rd.edit.olen
                                                                   : work_rd.edit.rlen);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        base_next      = base_reg;
        kept_next      = kept_reg;
        cur_next       = cur_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        load_raddr     = '0;
        work_raddr     = '0;
        work_wr        = 1'b0;
        work_waddr     = j_reg[IDX_W-1:0];
        work_wdata     = work_rd;

        case (state_reg)
            S_LOAD:
            begin
                if (edit_take)
                begin
                    if (load_wr)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (edit.final_edit)
                    begin
                        i_next     = '0;
                        num_next   = '0;
                        state_next = S_R_RDI;
                    end
                end
            end
            S_R_RDI:
            begin
                load_raddr = i_reg[IDX_W-1:0];
                state_next = S_R_GETI;
            end
            S_R_GETI:
            begin
                cur_next   = load_rd;
                load_raddr = '0;
                j_next     = '0;
                rank_next  = '0;
                if (load_rd.score < 0)
                begin
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == cnt_reg)
                    begin
                        i_next     = '0;
                        base_next  = '0;
                        state_next = (num_reg == '0) ? S_EMIT : S_W_RDI;
                    end
                    else
                    begin
                        state_next = S_R_RDI;
                    end
                end
                else
                begin
                    state_next = S_R_CNT;
                end
            end
            S_R_CNT:
            begin
                load_raddr = IDX_W'(j_reg + 1'b1);
                rank_next  = rank_reg + CNT_W'(better);
                j_next     = j_reg + 1'b1;
                if (j_reg + 1'b1 == cnt_reg)
                begin
                    state_next = S_R_WR;
                end
            end
            S_R_WR:
            begin
                work_wr    = 1'b1;
                work_waddr = rank_reg[IDX_W-1:0];
                work_wdata = '{edit: cur_reg, deferred: 1'b0};
                num_next   = num_reg + 1'b1;
                i_next     = i_reg + 1'b1;
                if (i_reg + 1'b1 == cnt_reg)
                begin
                    i_next     = '0;
                    base_next  = '0;
                    state_next = S_W_RDI;
                end
                else
                begin
                    state_next = S_R_RDI;
                end
            end
            S_W_RDI:
            begin
                work_raddr = i_reg[IDX_W-1:0];
                state_next = S_W_GETI;
            end
            S_W_GETI:
            begin
                work_raddr = IDX_W'(i_reg + 1'b1);
                cur_next   = work_rd.edit;
                kept_next  = !work_rd.deferred;
                j_next     = i_reg + 1'b1;
                if (!work_rd.deferred)
                begin
                    base_next = (base_sum > 15'(BASES_MAX)) ? BASES_MAX : base_sum[13:0];
                end
                if (!work_rd.deferred && (i_reg + 1'b1 < num_reg))
                begin
                    state_next = S_W_J;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_W_J:
            begin
                work_raddr = IDX_W'(j_reg + 1'b1);
                work_wr    = 1'b1;
                work_waddr = j_reg[IDX_W-1:0];
                if (near && !work_rd.deferred && (work_rd.edit.score > 0))
                begin
                    work_wdata.deferred = 1'b1;
                end
                else if ({1'b0, work_rd.edit.start} >= kept_end)
                begin
                    work_wdata.edit.start = shifted_sat;
                end
                j_next = j_reg + 1'b1;
                if (j_reg + 1'b1 == num_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    if (num_reg == '0)
                    begin
                        res_next              = '0;
                        res_next.final_result = 1'b1;
                    end
                    else
                    begin
                        res_next = '{entry_valid: 1'b1, was_kept: kept_reg,
                                     adjusted_start: cur_reg.start,
                                     out_original_length: cur_reg.olen,
                                     out_replacement_length: cur_reg.rlen,
                                     out_score: cur_reg.score,
                                     bases_changed: base_reg,
                                     final_result: (i_reg + 1'b1 == num_reg)};
                    end
                    if ((num_reg == '0) || (i_reg + 1'b1 == num_reg))
                    begin
                        cnt_next   = '0;
                        base_next  = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_W_RDI;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            num_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            base_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            num_reg       <= num_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rank_reg      <= rank_next;
            base_reg      <= base_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        kept_reg <= kept_next;
        res_reg  <= res_next;
    end

    // load count never passes the store depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_EDITS))
        else $error("load count beyond store depth");

    // survivors never outnumber loaded edits
    a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        num_reg <= cnt_reg || state_reg == S_EMIT || state_reg == S_LOAD)
        else $error("survivor count beyond load count");

    // a rank written to the work store lies below the load count
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_R_WR |-> rank_reg < cnt_reg)
        else $error("rank out of range");

    // the walk only updates entries after the current one
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W_J |-> (j_reg > i_reg && j_reg < num_reg))
        else $error("walk index out of order");

endmodule

[tb/sv/tb_greedy_spaced_edit_selector_top.sv]
// Testbench for greedy_spaced_edit_selector_top: directed edit table, then random batches.
// Results are checked against a bench predictor or, for typed rows, a stated result.
// Depends on gses_pkg and the block's RTL.
module tb_greedy_spaced_edit_selector_top;
    import gses_pkg::*;

    localparam int IDLE_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [7:0]   cfg_wr_data;
    logic         edit_valid;
    logic         edit_stall;
    edit_item_t   edit;
    logic         result_valid;
    logic         result_stall;
    result_item_t result;

    // bench copy of the spacing register and of the batch being loaded
    logic [7:0]   guard_model;
    edit_entry_t  batch_q[$];
    result_item_t want_q[$];
    bit           failed;
    bit           hold_req;
    int           idle_cycles;

    // directed table
    typedef struct {
        edit_item_t   item;
        bit           typed;
        result_item_t want;
    } edit_row_t;
    edit_row_t    rows[$];

    greedy_spaced_edit_selector_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .edit_valid   (edit_valid),
        .edit_stall   (edit_stall),
        .edit         (edit),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    // rank, walk and emit one batch; clears the batch afterwards
    function automatic void select_batch(ref result_item_t res_q[$]);
        int           rank[$];
        longint       pos[MAX_EDITS];
        bit           dfr[MAX_EDITS];
        int           total;
        int           j;
        longint       lo;
        longint       hi;
        edit_entry_t  e;
        edit_entry_t  f;
        result_item_t r;
        bit           kept;
        for (int i = 0; i < batch_q.size(); i++)
        begin
            if ($signed(batch_q[i].score) < 0)
                continue;
            j = rank.size();
            while (j > 0 && $signed(batch_q[rank[j-1]].score) < $signed(batch_q[i].score))
                j--;
            rank.insert(j, i);
        end
        for (int i = 0; i < rank.size(); i++)
        begin
            pos[i] = batch_q[rank[i]].start;
            dfr[i] = 0;
        end
        total = 0;
        for (int i = 0; i < rank.size(); i++)
        begin
            e = batch_q[rank[i]];
            kept = !dfr[i];
            if (kept)
            begin
                total += (e.olen > e.rlen) ? e.olen : e.rlen;
                if (total > BASES_MAX)
                    total = BASES_MAX;
                for (int k = i + 1; k < rank.size(); k++)
                begin
                    f = batch_q[rank[k]];
                    lo = (pos[i] > pos[k]) ? pos[i] : pos[k];
                    hi = (pos[i] + e.rlen < pos[k] + f.rlen) ? pos[i] + e.rlen : pos[k] + f.rlen;
                    if (lo < hi + guard_model && !dfr[k] && $signed(f.score) > 0)
                    begin
                        dfr[k] = 1;
                        continue;
                    end
                    if (pos[k] >= pos[i] + e.olen)
                    begin
                        pos[k] += longint'(e.rlen) - longint'(e.olen);
                        if (pos[k] > POS_MAX)
                            pos[k] = POS_MAX;
                        if (pos[k] < 0)
                            pos[k] = 0;
                    end
                end
            end
            r = '0;
            r.entry_valid = 1'b1;
            r.was_kept = kept;
            r.adjusted_start = pos[i][23:0];
            r.out_original_length = e.olen;
            r.out_replacement_length = e.rlen;
            r.out_score = e.score;
            r.bases_changed = total[13:0];
            r.final_result = (i + 1 == rank.size());
            res_q.insert(res_q.size(), r);
        end
        if (rank.size() == 0)
        begin
            r = '0;
            r.final_result = 1'b1;
            res_q.insert(res_q.size(), r);
        end
        batch_q.delete();
    endfunction

    // offer one item after a random gap, which may be zero, and wait until it is taken
    task automatic send_edit(input edit_item_t it, input bit typed, input result_item_t want);
        int           gap;
        result_item_t got_q[$];
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            edit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edit_valid <= 1'b1;
        edit <= it;
        do @(posedge clk); while (edit_stall);
        if (batch_q.size() < MAX_EDITS)
            batch_q.insert(batch_q.size(),
                           edit_entry_t'{it.edit_start, it.original_length,
                                         it.replacement_length, it.edit_score});
        if (it.final_edit)
        begin
            select_batch(got_q);
            if (typed)
                want_q.insert(want_q.size(), want);
            else
                foreach (got_q[i]) want_q.insert(want_q.size(), got_q[i]);
        end
    endtask

    task automatic send_plain(input edit_item_t it);
        send_edit(it, 1'b0, '0);
    endtask

    // random batch; narrow positions make spans collide, small score set makes ties
    task automatic rand_batch(input int n);
        edit_item_t it;
        for (int k = 0; k < n; k++)
        begin
            it.edit_start = ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                            24'($urandom_range(0, 400));
            it.original_length = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                 8'($urandom_range(0, 12));
            it.replacement_length = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                    8'($urandom_range(0, 12));
            case ($urandom_range(0, 5))
                0: it.edit_score = -$signed(32'($urandom_range(1, 200000)));
                1: it.edit_score = 32'sd0;
                2, 3: it.edit_score = $signed(32'($urandom_range(1, 4) << 16));
                default: it.edit_score = $signed(32'($urandom));
            endcase
            it.final_edit = (k == n - 1);
            send_plain(it);
        end
    endtask

    // register write once the block has drained
    task automatic set_guard(input logic [7:0] v);
        edit_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        guard_model = v;
    endtask

    task automatic add_row(input logic [23:0] s, input logic [7:0] ol, input logic [7:0] rl,
                           input logic [31:0] sc, input logic fin);
        rows.insert(rows.size(), '{'{s, ol, rl, $signed(sc), fin}, 1'b0, '0});
    endtask

    task automatic add_typed(input logic [23:0] s, input logic [7:0] ol, input logic [7:0] rl,
                             input logic [31:0] sc, input result_item_t want);
        rows.insert(rows.size(), '{'{s, ol, rl, $signed(sc), 1'b1}, 1'b1, want});
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (want_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                failed = 1;
            end
            else
            begin
                if (result !== want_q[0])
                begin
                    $display("%0t: result mismatch expected %p actual %p", $time, want_q[0],
                             result);
                    failed = 1;
                end
                void'(want_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((edit_valid && !edit_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("greedy_spaced_edit_selector_top test failed");
            $finish;
        end
    end

    // receiver stalls: mostly short, some long, one forced hold-off
    initial
    begin
        int run;
        bit held;
        held = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                result_stall <= 1'b1;
                repeat (run) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                run = $urandom_range(1, 20);
                repeat (run - 1) @(posedge clk);
            end
        end
    end

    // main sequence
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        edit_valid = 1'b0;
        edit = '0;
        guard_model = GUARD_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single edits with results read straight off the rules
        add_typed(24'd5, 8'd3, 8'd1, 32'hFFFF_0000,
                  result_item_t'{1'b0, 1'b0, 24'd0, 8'd0, 8'd0, 32'sd0, 14'd0, 1'b1});
        add_typed(24'd0, 8'd0, 8'd0, 32'h0,
                  result_item_t'{1'b1, 1'b1, 24'd0, 8'd0, 8'd0, 32'sd0, 14'd0, 1'b1});
        add_typed(24'hFFFFFF, 8'hFF, 8'hFF, 32'h7FFF_FFFF,
                  result_item_t'{1'b1, 1'b1, 24'hFFFFFF, 8'hFF, 8'hFF, 32'sh7FFF_FFFF,
                                 14'd255, 1'b1});
        add_typed(24'hAAAAAA, 8'hAA, 8'h55, 32'h8000_0000,
                  result_item_t'{1'b0, 1'b0, 24'd0, 8'd0, 8'd0, 32'sd0, 14'd0, 1'b1});
        // overlap, tie order, zero score shifted, negative dropped
        add_row(24'd100, 8'd4, 8'd10, 32'h0002_0000, 1'b0);
        add_row(24'd105, 8'd2, 8'd2, 32'h0002_0000, 1'b0);
        add_row(24'd200, 8'd1, 8'd9, 32'h0, 1'b0);
        add_row(24'd150, 8'd3, 8'd0, 32'hFFFF_FFFF, 1'b0);
        add_row(24'd300, 8'd20, 8'd0, 32'h0005_0000, 1'b1);
        // shift saturating at the top position
        add_row(24'd0, 8'd0, 8'hFF, 32'h0010_0000, 1'b0);
        add_row(24'hFFFFF0, 8'd1, 8'd1, 32'h0, 1'b1);
        // shift down toward zero and a deferred zero-length neighbor
        add_row(24'd10, 8'hFF, 8'd0, 32'h0003_0000, 1'b0);
        add_row(24'd265, 8'd1, 8'd1, 32'h0001_0000, 1'b0);
        add_row(24'd12, 8'd0, 8'd0, 32'h0002_0000, 1'b1);
        foreach (rows[i]) send_edit(rows[i].item, rows[i].typed, rows[i].want);

        set_guard(8'd0);
        rand_batch(1);
        rand_batch(6);
        rand_batch(4);
        set_guard(8'd255);
        rand_batch(8);
        rand_batch(3);

        // hold off the receiver while batches keep coming
        set_guard(8'($urandom));
        hold_req = 1;
        rand_batch(5);
        rand_batch(2);
        rand_batch(7);
        rand_batch(3);

        // full store: the final edit lands past the last entry
        set_guard(8'($urandom_range(1, 254)));
        rand_batch(66);
        rand_batch(3);

        edit_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("greedy_spaced_edit_selector_top test passed");
        else
            $display("greedy_spaced_edit_selector_top test failed");
        $finish;
    end

endmodule
